// File: hdl/mtcs_pkg.sv
package mtcs_pkg;

    // Field widths of the input and result transactions.
    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 4;
    localparam int PERIOD_W = 32;
    localparam int STATUS_W = 2;
    localparam int ID_W     = 4;
    localparam int MASK_W   = 16;
    localparam int TICKS_W  = 32;
    localparam int INUSE_W  = 5;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_FIELDS_W = INDEX_W + PERIOD_W + 2;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = OPCODE_W;
    localparam int M_FIELDS_W = STATUS_W + ID_W + MASK_W + TICKS_W + INUSE_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Operation codes carried in s_tuser.
    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK       = 3'd0,
        OP_REGISTER   = 3'd1,
        OP_ACT_COUNT  = 3'd2,
        OP_ACT_STORED = 3'd3,
        OP_ACT_PERIOD = 3'd4,
        OP_DEACTIVATE = 3'd5
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_TABLE_FULL  = 2'd1,
        ST_BAD_INDEX   = 2'd2,
        ST_ZERO_PERIOD = 2'd3
    } status_t;

    // Control into the per-entry update unit.
    typedef struct packed {
        logic fire_mode;
        logic cont;
    } upd_ctrl_t;

    // Flags out of the per-entry update unit.
    typedef struct packed {
        logic fired;
        logic stay_active;
    } upd_res_t;

endpackage

// File: hdl/mtcs_entry_update.sv
module mtcs_entry_update
    import mtcs_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  upd_ctrl_t              ctrl,
    input  logic [COUNT_WIDTH-1:0] remaining,
    input  logic [COUNT_WIDTH-1:0] period,
    input  logic [COUNT_WIDTH-1:0] delta,
    output logic [COUNT_WIDTH-1:0] new_remaining,
    output upd_res_t               res
);

    logic                   expired;
    logic [COUNT_WIDTH-1:0] diff;

    // An entry has expired when the elapsed time reaches its remaining count.
    assign expired = (remaining <= delta);
    assign diff    = remaining - delta;

    // Expiry pass reloads fired entries; accounting clamps at one.
    always_comb begin
        if (ctrl.fire_mode) begin
            new_remaining   = expired ? period : diff;
            res.fired       = expired;
            res.stay_active = !expired || ctrl.cont;
        end else begin
            new_remaining   = expired ? COUNT_WIDTH'(1) : diff;
            res.fired       = 1'b0;
            res.stay_active = 1'b1;
        end
    end

endmodule

// File: hdl/multi_timer_countdown_scheduler.sv
// A tick that does not expire, or an op that is rejected, goes from S_DECODE straight to
// S_OUT; s_tready is high only in S_IDLE, so a new transaction waits for the registered result.
// Expiry and accounting walk every registered entry through the one read port of the
// remaining-count memory in S_WALK, then pass through S_APPLY and S_OUT. A registration
// or activation with no elapsed ticks skips the walk and goes straight to S_APPLY.
// Reset (aresetn low, synchronous) deactivates all timers, clears the count and sets
// both countdowns, the window and the ticks left, to all ones.
module multi_timer_countdown_scheduler
    import mtcs_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0: timer_sel[3:0], period_ticks[35:4], continuous[36],
    // start_active[37].
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0: opcode[2:0].
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0: status[1:0], assigned_id[5:2], fired_mask[21:6],
    // ticks_to_next[53:22], timers_in_use[58:54].
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_APPLY,
        S_OUT
    } state_t;

    // Control state.
    state_t                 state_reg, state_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [TABLE_DEPTH-1:0] active_reg, active_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [COUNT_WIDTH-1:0] window_reg, window_next;
    logic [COUNT_WIDTH-1:0] ticks_reg, ticks_next;
    logic                   p_valid_reg, p_valid_next;
    logic                   cand_valid_reg, cand_valid_next;

    // Payload state.
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [TABLE_DEPTH-1:0] cont_reg, cont_next;
    op_t                    op_reg, op_next;
    logic [INDEX_W-1:0]     idx_reg, idx_next;
    logic [COUNT_WIDTH-1:0] count_in_reg, count_in_next;
    logic                   cont_in_reg, cont_in_next;
    logic                   start_in_reg, start_in_next;
    logic [COUNT_WIDTH-1:0] use_reg, use_next;
    logic [COUNT_WIDTH-1:0] delta_reg, delta_next;
    logic [COUNT_WIDTH-1:0] best_reg, best_next;
    logic [COUNT_WIDTH-1:0] cand_reg, cand_next;
    logic                   fire_mode_reg, fire_mode_next;
    logic [CNT_W-1:0]       issue_reg, issue_next;
    logic [IDX_W-1:0]       p_idx_reg, p_idx_next;
    logic [TABLE_DEPTH-1:0] fired_reg, fired_next;
    status_t                status_reg, status_next;
    logic [ID_W-1:0]        assigned_reg, assigned_next;

    // Timer memories: remaining counts and reload periods.
    logic [COUNT_WIDTH-1:0] rem_mem [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] per_mem [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] rem_rdata_reg;
    logic [COUNT_WIDTH-1:0] per_rdata_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic                   rem_we;
    logic [IDX_W-1:0]       rem_wa;
    logic [COUNT_WIDTH-1:0] rem_wd;
    logic                   per_we;
    logic [IDX_W-1:0]       per_wa;
    logic [COUNT_WIDTH-1:0] per_wd;

    // Per-entry update unit and decode helpers.
    upd_ctrl_t              upd_ctrl;
    upd_res_t               upd_res;
    logic [COUNT_WIDTH-1:0] upd_rem;
    logic [COUNT_WIDTH-1:0] act_use;
    logic [IDX_W-1:0]       app_addr;
    logic                   offer_en;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign upd_ctrl.fire_mode = fire_mode_reg;
    assign upd_ctrl.cont      = cont_reg[p_idx_reg];

    mtcs_entry_update #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_update (
        .ctrl          (upd_ctrl),
        .remaining     (rem_rdata_reg),
        .period        (per_rdata_reg),
        .delta         (delta_reg),
        .new_remaining (upd_rem),
        .res           (upd_res)
    );

    // Count used by an activation: the stored period or the one given.
    assign act_use  = (op_reg == OP_ACT_STORED) ? per_rdata_reg : count_in_reg;
    assign app_addr = (op_reg == OP_REGISTER) ? IDX_W'(count_reg) : IDX_W'(idx_reg);
    assign offer_en = (op_reg == OP_REGISTER) ? start_in_reg : 1'b1;

    // Memories with registered read data.
    always_ff @(posedge aclk) begin
        if (rem_we) begin
            rem_mem[rem_wa] <= rem_wd;
        end
        rem_rdata_reg <= rem_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (per_we) begin
            per_mem[per_wa] <= per_wd;
        end
        per_rdata_reg <= per_mem[rd_addr];
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next      = state_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        active_next     = active_reg;
        cont_next       = cont_reg;
        count_next      = count_reg;
        window_next     = window_reg;
        ticks_next      = ticks_reg;
        p_valid_next    = p_valid_reg;
        cand_valid_next = cand_valid_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        count_in_next   = count_in_reg;
        cont_in_next    = cont_in_reg;
        start_in_next   = start_in_reg;
        use_next        = use_reg;
        delta_next      = delta_reg;
        best_next       = best_reg;
        cand_next       = cand_reg;
        fire_mode_next  = fire_mode_reg;
        issue_next      = issue_reg;
        p_idx_next      = p_idx_reg;
        fired_next      = fired_reg;
        status_next     = status_reg;
        assigned_next   = assigned_reg;
        rd_addr         = issue_reg[IDX_W-1:0];
        rem_we          = 1'b0;
        rem_wa          = app_addr;
        rem_wd          = use_reg;
        per_we          = 1'b0;
        per_wa          = app_addr;
        per_wd          = use_reg;

        // The result register empties when its transaction completes.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                // Address the stored period of the addressed timer right away.
                rd_addr = IDX_W'(s_tdata[INDEX_W-1:0]);
                if (s_tvalid) begin
                    op_next       = op_t'(s_tuser[OPCODE_W-1:0]);
                    idx_next      = s_tdata[INDEX_W-1:0];
                    count_in_next = COUNT_WIDTH'(s_tdata[INDEX_W +: PERIOD_W]);
                    cont_in_next  = s_tdata[INDEX_W + PERIOD_W];
                    start_in_next = s_tdata[INDEX_W + PERIOD_W + 1];
                    state_next    = S_DECODE;
                end
            end

            S_DECODE: begin
                status_next     = ST_OK;
                assigned_next   = '0;
                fired_next      = '0;
                best_next       = '1;
                issue_next      = '0;
                p_valid_next    = 1'b0;
                cand_valid_next = 1'b0;
                fire_mode_next  = 1'b0;
                state_next      = S_OUT;
                unique case (op_reg) inside
                    OP_TICK: begin
                        if (ticks_reg != '0) begin
                            ticks_next = ticks_reg - COUNT_WIDTH'(1);
                        end
                        // Countdown reaches zero: run the expiry pass.
                        if (ticks_reg <= COUNT_WIDTH'(1)) begin
                            fire_mode_next = 1'b1;
                            delta_next     = window_reg;
                            state_next     = S_WALK;
                        end
                    end
                    OP_REGISTER: begin
                        if (count_reg >= CNT_W'(TABLE_DEPTH)) begin
                            status_next = ST_TABLE_FULL;
                        end else if (count_in_reg == '0) begin
                            status_next = ST_ZERO_PERIOD;
                        end else begin
                            use_next   = count_in_reg;
                            delta_next = window_reg - ticks_reg;
                            if (window_reg != ticks_reg) begin
                                window_next = ticks_reg;
                                state_next  = S_WALK;
                            end else begin
                                state_next = S_APPLY;
                            end
                        end
                    end
                    OP_ACT_COUNT, OP_ACT_STORED, OP_ACT_PERIOD, OP_DEACTIVATE: begin
                        if (32'(idx_reg) >= 32'(count_reg)) begin
                            status_next = ST_BAD_INDEX;
                        end else if (op_reg == OP_DEACTIVATE) begin
                            active_next[IDX_W'(idx_reg)] = 1'b0;
                        end else if (act_use == '0) begin
                            status_next = ST_ZERO_PERIOD;
                        end else begin
                            use_next   = act_use;
                            delta_next = window_reg - ticks_reg;
                            if (window_reg != ticks_reg) begin
                                window_next = ticks_reg;
                                state_next  = S_WALK;
                            end else begin
                                state_next = S_APPLY;
                            end
                        end
                    end
                    default: begin
                        status_next = ST_OK;
                    end
                endcase
            end

            S_WALK: begin
                // Issue one read per registered entry.
                if (issue_reg != count_reg) begin
                    issue_next   = issue_reg + CNT_W'(1);
                    p_valid_next = 1'b1;
                    p_idx_next   = issue_reg[IDX_W-1:0];
                end else begin
                    p_valid_next = 1'b0;
                end

                // Update the entry whose data arrived and write it back.
                cand_valid_next = 1'b0;
                cand_next       = upd_rem;
                if (p_valid_reg && active_reg[p_idx_reg]) begin
                    rem_we = 1'b1;
                    rem_wa = p_idx_reg;
                    rem_wd = upd_rem;
                    if (fire_mode_reg) begin
                        fired_next[p_idx_reg]  = upd_res.fired;
                        active_next[p_idx_reg] = upd_res.stay_active;
                        cand_valid_next        = upd_res.stay_active;
                    end
                end

                // Running minimum of the counts that stay active.
                if (cand_valid_reg && (cand_reg < best_reg)) begin
                    best_next = cand_reg;
                end

                if ((issue_reg == count_reg) && !p_valid_reg) begin
                    state_next = S_APPLY;
                end
            end

            S_APPLY: begin
                state_next = S_OUT;
                if (fire_mode_reg) begin
                    window_next = best_reg;
                    ticks_next  = best_reg;
                end else begin
                    rem_we = 1'b1;
                    if (op_reg == OP_REGISTER) begin
                        per_we                = 1'b1;
                        active_next[app_addr] = start_in_reg;
                        count_next            = count_reg + CNT_W'(1);
                        assigned_next         = ID_W'(count_reg);
                    end else begin
                        per_we                = (op_reg == OP_ACT_PERIOD);
                        active_next[app_addr] = 1'b1;
                    end
                    cont_next[app_addr] = cont_in_reg;
                    // A sooner expiry shortens the countdown.
                    if (offer_en && (use_reg < ticks_reg)) begin
                        window_next = use_reg;
                        ticks_next  = use_reg;
                    end
                end
            end

            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {
                        (M_TDATA_W - M_FIELDS_W)'(0),
                        INUSE_W'(count_reg),
                        TICKS_W'(ticks_reg),
                        MASK_W'(fired_reg),
                        assigned_reg,
                        status_reg
                    };
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            active_reg     <= '0;
            count_reg      <= '0;
            window_reg     <= '1;
            ticks_reg      <= '1;
            p_valid_reg    <= 1'b0;
            cand_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            active_reg     <= active_next;
            count_reg      <= count_next;
            window_reg     <= window_next;
            ticks_reg      <= ticks_next;
            p_valid_reg    <= p_valid_next;
            cand_valid_reg <= cand_valid_next;
        end
        m_tdata_reg   <= m_tdata_next;
        cont_reg      <= cont_next;
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        count_in_reg  <= count_in_next;
        cont_in_reg   <= cont_in_next;
        start_in_reg  <= start_in_next;
        use_reg       <= use_next;
        delta_reg     <= delta_next;
        best_reg      <= best_next;
        cand_reg      <= cand_next;
        fire_mode_reg <= fire_mode_next;
        issue_reg     <= issue_next;
        p_idx_reg     <= p_idx_next;
        fired_reg     <= fired_next;
        status_reg    <= status_next;
        assigned_reg  <= assigned_next;
    end

    // The registered count never exceeds the table size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("registered timer count beyond table size");

    // The walk never issues past the registered entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (issue_reg <= count_reg))
        else $error("table walk ran past the registered entries");

    // Only an expiry pass can report fired timers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && !fire_mode_reg) |-> (fired_reg == '0))
        else $error("fired timers reported outside an expiry pass");

    // After an expiry pass a fresh window starts at the new countdown.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_APPLY && fire_mode_reg) |=> (ticks_reg == window_reg))
        else $error("countdown and window disagree after expiry");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mtcs_pkg::*;

    localparam int TIMER_COUNT  = 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_COUNT  = 5;

    // Opcodes the block ignores; the package gives them no name.
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  index;
        logic [PERIOD_W-1:0] period;
        logic                cont;
        logic                start;
    } timer_cmd_t;

    typedef struct {
        status_t             status;
        logic [ID_W-1:0]     id;
        logic [MASK_W-1:0]   fired;
        logic [TICKS_W-1:0]  ticks;
        logic [INUSE_W-1:0]  in_use;
    } timer_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    timer_cmd_t    cmd_queue[$];
    timer_result_t expected_results[$];
    timer_cmd_t    cmd_in_flight;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            error_count    = 0;
    int            cycle_count    = 0;

    // Predicted timer table and countdown.
    logic [PERIOD_W-1:0] sched_period    [TIMER_COUNT];
    logic [PERIOD_W-1:0] sched_remaining [TIMER_COUNT];
    logic                sched_active    [TIMER_COUNT];
    logic                sched_cont      [TIMER_COUNT];
    int                  sched_in_use = 0;
    logic [PERIOD_W-1:0] sched_window = '1;
    logic [PERIOD_W-1:0] sched_left   = '1;

    multi_timer_countdown_scheduler u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        for (int i = 0; i < TIMER_COUNT; i++) begin
            sched_active[i] = 1'b0;
        end
    end

    // Fold the ticks elapsed since the countdown was loaded into every active timer.
    function automatic void fold_elapsed();
        logic [PERIOD_W-1:0] delta;
        delta = sched_window - sched_left;
        if (delta != 0) begin
            for (int i = 0; i < sched_in_use; i++) begin
                if (sched_active[i]) begin
                    sched_remaining[i] = (sched_remaining[i] > delta) ?
                                         sched_remaining[i] - delta : 1;
                end
            end
            sched_window = sched_left;
        end
    endfunction

    // A newly started count may bring the next expiry forward.
    function automatic void shorten_countdown(logic [PERIOD_W-1:0] count);
        if (count < sched_left) begin
            sched_window = count;
            sched_left   = count;
        end
    endfunction

    // Apply one command to the predicted table and return the result it gives.
    function automatic timer_result_t predict_result(timer_cmd_t cmd);
        timer_result_t       res;
        logic [PERIOD_W-1:0] delta;
        logic [PERIOD_W-1:0] nearest;
        logic [PERIOD_W-1:0] use_count;
        res.status = ST_OK;
        res.id     = '0;
        res.fired  = '0;
        case (cmd.opcode)
            OP_TICK: begin
                if (sched_left != 0) sched_left = sched_left - 1;
                if (sched_left == 0) begin
                    // Expiry pass: fire and reload, then find the nearest expiry.
                    delta   = sched_window - sched_left;
                    nearest = '1;
                    for (int i = 0; i < sched_in_use; i++) begin
                        if (sched_active[i]) begin
                            if (sched_remaining[i] <= delta) begin
                                res.fired[i]       = 1'b1;
                                sched_remaining[i] = sched_period[i];
                                if (!sched_cont[i]) sched_active[i] = 1'b0;
                            end else begin
                                sched_remaining[i] = sched_remaining[i] - delta;
                            end
                        end
                    end
                    for (int i = 0; i < sched_in_use; i++) begin
                        if (sched_active[i] && sched_remaining[i] < nearest)
                            nearest = sched_remaining[i];
                    end
                    sched_window = nearest;
                    sched_left   = nearest;
                end
            end
            OP_REGISTER: begin
                if (sched_in_use >= TIMER_COUNT) begin
                    res.status = ST_TABLE_FULL;
                end else if (cmd.period == 0) begin
                    res.status = ST_ZERO_PERIOD;
                end else begin
                    fold_elapsed();
                    res.id                        = ID_W'(sched_in_use);
                    sched_period[sched_in_use]    = cmd.period;
                    sched_remaining[sched_in_use] = cmd.period;
                    sched_active[sched_in_use]    = cmd.start;
                    sched_cont[sched_in_use]      = cmd.cont;
                    sched_in_use++;
                    if (cmd.start) shorten_countdown(cmd.period);
                end
            end
            OP_ACT_COUNT, OP_ACT_STORED, OP_ACT_PERIOD, OP_DEACTIVATE: begin
                if (cmd.index >= sched_in_use) begin
                    res.status = ST_BAD_INDEX;
                end else if (cmd.opcode == OP_DEACTIVATE) begin
                    sched_active[cmd.index] = 1'b0;
                end else begin
                    use_count = (cmd.opcode == OP_ACT_STORED) ? sched_period[cmd.index]
                                                              : cmd.period;
                    if (use_count == 0) begin
                        res.status = ST_ZERO_PERIOD;
                    end else begin
                        fold_elapsed();
                        sched_cont[cmd.index] = cmd.cont;
                        if (cmd.opcode == OP_ACT_PERIOD) sched_period[cmd.index] = use_count;
                        sched_active[cmd.index]    = 1'b1;
                        sched_remaining[cmd.index] = use_count;
                        shorten_countdown(use_count);
                    end
                end
            end
            default: begin
            end
        endcase
        res.ticks  = sched_left;
        res.in_use = INUSE_W'(sched_in_use);
        return res;
    endfunction

    function automatic void push_cmd(logic [OPCODE_W-1:0] opcode, logic [INDEX_W-1:0] index,
                                     logic [PERIOD_W-1:0] period, logic cont, logic start);
        timer_cmd_t cmd;
        cmd.opcode = opcode;
        cmd.index  = index;
        cmd.period = period;
        cmd.cont   = cont;
        cmd.start  = start;
        cmd_queue.push_back(cmd);
    endfunction

    // Input driver: predict each accepted transaction, then offer the next command.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_result(cmd_in_flight));
            if (!s_tvalid || s_tready) begin
                if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cmd_in_flight = cmd_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({cmd_in_flight.start, cmd_in_flight.cont,
                                            cmd_in_flight.period, cmd_in_flight.index});
                    s_tuser  <= cmd_in_flight.opcode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted transaction with the oldest prediction.
    always @(posedge aclk) begin : result_monitor
        timer_result_t got;
        timer_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tdata[1:0]);
                got.id     = m_tdata[5:2];
                got.fired  = m_tdata[21:6];
                got.ticks  = m_tdata[53:22];
                got.in_use = m_tdata[58:54];
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected result: status %0d id %0d fired %h ticks %h in use %0d",
                                 got.status, got.id, got.fired, got.ticks, got.in_use);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.id !== want.id ||
                        got.fired !== want.fired || got.ticks !== want.ticks ||
                        got.in_use !== want.in_use) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display("mismatch at cycle %0d", cycle_count);
                            $display("  expected: status %0d id %0d fired %h ticks %h in use %0d",
                                     want.status, want.id, want.fired, want.ticks, want.in_use);
                            $display("  actual:   status %0d id %0d fired %h ticks %h in use %0d",
                                     got.status, got.id, got.fired, got.ticks, got.in_use);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Stimulus: a directed opening, then random traffic under several idle patterns.
    initial begin
        int                  pick;
        int                  period_pick;
        logic [PERIOD_W-1:0] count;
        logic [OPCODE_W-1:0] opcode;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                2:       begin send_idle_pct = 81; recv_stall_pct = 0;  end
                3:       begin send_idle_pct = 0;  recv_stall_pct = 81; end
                4:       begin send_idle_pct = 6;  recv_stall_pct = 6;  end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase

            if (phase == 0) begin
                // Empty table: tick from all ones, bad indexes, zero period, spare opcodes.
                push_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 1'b0);
                push_cmd(OP_DEACTIVATE, 4'd0, 32'd0, 1'b0, 1'b0);
                push_cmd(OP_ACT_COUNT, 4'd15, 32'd5, 1'b1, 1'b0);
                push_cmd(OP_ACT_STORED, 4'd0, 32'd0, 1'b0, 1'b0);
                push_cmd(OP_ACT_PERIOD, 4'd0, 32'd7, 1'b1, 1'b0);
                push_cmd(OP_REGISTER, 4'd0, 32'd0, 1'b1, 1'b1);
                push_cmd(OP_SPARE_LO, 4'd15, '1, 1'b1, 1'b1);
                push_cmd(OP_SPARE_HI, 4'd0, 32'd0, 1'b0, 1'b0);
                // A continuous timer fires after three ticks; a dormant one-shot beside it.
                push_cmd(OP_REGISTER, 4'd0, 32'd3, 1'b1, 1'b1);
                push_cmd(OP_REGISTER, 4'd15, '1, 1'b0, 1'b0);
                push_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 1'b0);
                push_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 1'b0);
                push_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 1'b0);
                // Activations of the one-shot: zero count, stored period, then a new period.
                push_cmd(OP_ACT_COUNT, 4'd1, 32'd0, 1'b0, 1'b0);
                push_cmd(OP_ACT_STORED, 4'd1, 32'd0, 1'b0, 1'b0);
                push_cmd(OP_ACT_PERIOD, 4'd1, 32'd2, 1'b0, 1'b0);
                push_cmd(OP_DEACTIVATE, 4'd0, 32'd0, 1'b0, 1'b0);
                push_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 1'b0);
                push_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 1'b0);
                // Nothing active: the countdown falls back to all ones.
                push_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 1'b0);
                push_cmd(OP_ACT_STORED, 4'd1, 32'd0, 1'b1, 1'b0);
                push_cmd(OP_ACT_COUNT, 4'd0, 32'd4, 1'b1, 1'b0);
                push_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 1'b0);
                push_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 1'b0);
            end else begin
                // Ticks lead the mix and most periods are short, so that expiries come often.
                for (int n = 0; n < RANDOM_ITEMS / (PHASE_COUNT - 1); n++) begin
                    pick        = $urandom_range(0, 99);
                    period_pick = $urandom_range(0, 99);
                    if (period_pick < 5)
                        count = '0;
                    else if (period_pick < 11)
                        count = $urandom;
                    else
                        count = $urandom_range(1, 12);
                    if (pick < 48)      opcode = OP_TICK;
                    else if (pick < 58) opcode = OP_REGISTER;
                    else if (pick < 70) opcode = OP_ACT_COUNT;
                    else if (pick < 78) opcode = OP_ACT_STORED;
                    else if (pick < 88) opcode = OP_ACT_PERIOD;
                    else if (pick < 96) opcode = OP_DEACTIVATE;
                    else                opcode = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
                    push_cmd(opcode, INDEX_W'($urandom_range(0, 15)), count,
                             1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
                end
            end

            // Hold off new commands until every outstanding result has come back.
            while (cmd_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
                @(negedge aclk);
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        error_count += expected_results.size();
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
